// ===== rtl/dsi_pkg.sv =====
// ----------------------------------------------------------------------------
// dsi_pkg
// Shared types and constants for the dedispersion select index block.
// ----------------------------------------------------------------------------
package dsi_pkg;

	localparam int MAX_CHANNELS = 4096;
	localparam int CNT_W        = $clog2(MAX_CHANNELS);
	localparam int CH_W         = 12;
	localparam int WORD_W       = 32;
	localparam int FREQ_X_W     = 33;
	localparam int SUM_W        = 47;

	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W    = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_DM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RF = 2'd2;

	localparam logic [WORD_W-1:0] DM_RESET = 32'd0;
	localparam logic [WORD_W-1:0] TS_RESET = 32'd1;
	localparam logic [WORD_W-1:0] RF_RESET = 32'd65536;

	localparam logic [FREQ_X_W-1:0] DELAY_CONST = 33'd4150;
	localparam int SCALE_SHIFT  = 40;

	// Multiplier: wide operand in 32-bit limbs times a 33-bit operand.
	localparam int LIMBS        = 5;
	localparam int A_W          = LIMBS * 32;
	localparam int LIMB_IDX_W   = $clog2(LIMBS);
	localparam int MUL_CNT_W    = $clog2(LIMBS + 1);
	localparam int PROD_W       = 32 + FREQ_X_W;
	localparam int ACC_W        = 162;
	localparam int SQ_W         = 66;
	localparam int R2_W         = 64;
	localparam int NUM_W        = 151;
	localparam int DSH_W        = ACC_W + 32;
	localparam int BIT_W        = 5;

	localparam logic signed [WORD_W-1:0] START_MAX = 32'sh7FFFFFFF;
	localparam logic signed [WORD_W-1:0] START_MIN = 32'sh80000000;

	typedef enum logic [1:0] {
		KIND_HOLD,
		KIND_LONE,
		KIND_SECOND,
		KIND_NEXT
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [WORD_W-1:0]    freq;
		logic [FREQ_X_W-1:0]  aux_freq;
		logic [CH_W-1:0]      ch;
		logic                 fin;
	} job_t;

	typedef struct packed {
		logic [WORD_W-1:0] dm;
		logic [WORD_W-1:0] ts;
		logic [WORD_W-1:0] rf;
	} cfg_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] start;
		logic                     sat;
	} delay_res_t;

	typedef enum logic [3:0] {
		DL_IDLE,
		DL_SQF,
		DL_SQR,
		DL_DIFF,
		DL_NUM1,
		DL_NUM2,
		DL_DEN1,
		DL_DEN2,
		DL_DEN3,
		DL_CHK,
		DL_DIV,
		DL_FIN,
		DL_DONE
	} dl_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MAIN,
		BK_AUX,
		BK_OUT_FIRST,
		BK_OUT_LAST
	} bk_state_t;

endpackage

// ===== rtl/dedispersion_select_index_core.sv =====
// ----------------------------------------------------------------------------
// dedispersion_select_index_core
// Per-channel dispersion delay, window end and running window width.
// ----------------------------------------------------------------------------
// Channel words enter on item_valid/item_stall, one frequency each with a
// final_channel mark, in ascending order. Result words leave on
// result_valid/result_stall. Registers are written on cfg_valid/cfg_ready;
// cfg_ready is always high and writes are expected only while idle.
// A front stage counts and classifies channels and places them in a
// two-entry queue; it takes a new word whenever that queue has room.
// The back stage runs one delay calculation at a time in a sequential unit:
// a 32x33 limb multiplier (21 steps over seven products) and a restoring
// divider (one quotient bit per cycle) give the delay.
// Channel 0 gives no word of its own; channel 1 needs a second delay for
// the imaginary channel and gives two words.
// A lone channel gives one word. The result register holds its word while
// result_stall is high, and the back stage waits; the queue then fills and
// item_stall rises. Reset clears the run state, the queue and the
// registers to their defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module dedispersion_select_index_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [dsi_pkg::WORD_W-1:0]          freq_mhz,
	input  logic                                final_channel,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [dsi_pkg::CH_W-1:0]            channel_number,
	output logic signed [dsi_pkg::WORD_W-1:0]   start_index,
	output logic signed [dsi_pkg::WORD_W-1:0]   end_index,
	output logic [dsi_pkg::SUM_W-1:0]           width_total,
	output logic                                saturated,
	output logic                                run_end,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dsi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dsi_pkg::WORD_W-1:0]          cfg_data
);
	import dsi_pkg::*;

	cfg_t                cfg_q;
	logic                push;
	logic                pop;
	logic                q_full;
	logic                q_empty;
	job_t                wr_job;
	job_t                rd_job;
	logic                dl_start;
	logic [FREQ_X_W-1:0] dl_freq;
	logic                dl_done;
	delay_res_t          dl_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dm <= DM_RESET;
			cfg_q.ts <= TS_RESET;
			cfg_q.rf <= RF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DM:  cfg_q.dm <= cfg_data;
				CFG_TS:  cfg_q.ts <= cfg_data;
				CFG_RF:  cfg_q.rf <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	dsi_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.freq_mhz      (freq_mhz),
		.final_channel (final_channel),
		.q_full        (q_full),
		.push          (push),
		.job           (wr_job)
	);

	dsi_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	dsi_delay u_delay (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dl_start),
		.freq   (dl_freq),
		.cfg    (cfg_q),
		.done   (dl_done),
		.res    (dl_res)
	);

	dsi_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_job          (rd_job),
		.pop            (pop),
		.dl_start       (dl_start),
		.dl_freq        (dl_freq),
		.dl_done        (dl_done),
		.dl_res         (dl_res),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.channel_number (channel_number),
		.start_index    (start_index),
		.end_index      (end_index),
		.width_total    (width_total),
		.saturated      (saturated),
		.run_end        (run_end)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("queue read while empty");

	a_end_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($signed(end_index) >= $signed(start_index)))
		else $error("window end below window start");

endmodule

// ===== rtl/dsi_queue.sv =====
// ----------------------------------------------------------------------------
// dsi_queue
// Short job queue between the classifying front and the computing back.
// ----------------------------------------------------------------------------
module dsi_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dsi_pkg::job_t wr_job,
	input  logic          pop,
	output dsi_pkg::job_t rd_job,
	output logic          full,
	output logic          empty
);
	import dsi_pkg::*;

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full   = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/dsi_front.sv =====
// ----------------------------------------------------------------------------
// dsi_front
// Accepts channel words, tracks the channel count and classifies each one.
// ----------------------------------------------------------------------------
module dsi_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [dsi_pkg::WORD_W-1:0]  freq_mhz,
	input  logic                        final_channel,
	input  logic                        q_full,
	output logic                        push,
	output dsi_pkg::job_t               job
);
	import dsi_pkg::*;

	logic [CNT_W-1:0]    count_q;
	logic [WORD_W-1:0]   first_freq_q;
	logic                fin;
	logic [FREQ_X_W-1:0] two_f0;
	logic [FREQ_X_W-1:0] f_ext;

	assign item_stall = q_full;
	assign push       = item_valid && !q_full;

	always_comb begin
		// The list is cut short one channel before the table would overflow.
		fin    = final_channel || (count_q == CNT_W'(MAX_CHANNELS - 1));
		two_f0 = {first_freq_q, 1'b0};
		f_ext  = {1'b0, freq_mhz};
		job.freq     = freq_mhz;
		job.aux_freq = (two_f0 >= f_ext) ? (two_f0 - f_ext) : (f_ext - two_f0);
		job.ch       = CH_W'(count_q);
		job.fin      = fin;
		if (count_q == '0) begin
			job.kind = fin ? KIND_LONE : KIND_HOLD;
		end else if (count_q == CNT_W'(1)) begin
			job.kind = KIND_SECOND;
		end else begin
			job.kind = KIND_NEXT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			first_freq_q <= '0;
		end else if (push) begin
			if (count_q == '0) begin
				first_freq_q <= freq_mhz;
			end
			count_q <= fin ? '0 : count_q + 1'b1;
		end
	end

endmodule

// ===== rtl/dsi_delay.sv =====
// ----------------------------------------------------------------------------
// dsi_delay
// Sequential delay unit: limb-serial multiplier and restoring divider that
// give the truncated, saturated dispersion delay of one frequency.
// ----------------------------------------------------------------------------
module dsi_delay (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dsi_pkg::FREQ_X_W-1:0]  freq,
	input  dsi_pkg::cfg_t                 cfg,
	output logic                          done,
	output dsi_pkg::delay_res_t           res
);
	import dsi_pkg::*;

	dl_state_t               state_q;
	dl_state_t               state_d;
	logic [LIMBS-1:0][31:0]  a_q;
	logic [FREQ_X_W-1:0]     b_q;
	logic [MUL_CNT_W-1:0]    cnt_q;
	logic [ACC_W-1:0]        acc_q;
	logic [SQ_W-1:0]         f2_q;
	logic [R2_W-1:0]         r2_q;
	logic                    neg_q;
	logic [NUM_W-1:0]        rem_q;
	logic [DSH_W-1:0]        dsh_q;
	logic [BIT_W-1:0]        bit_q;
	logic [WORD_W-1:0]       q_q;
	delay_res_t              res_q;

	logic                    mul_busy;
	logic [LIMB_IDX_W-1:0]   limb_idx;
	logic [PROD_W-1:0]       prod;
	logic [ACC_W-1:0]        acc_next;
	logic [DSH_W-1:0]        rem_ext;
	logic [DSH_W-1:0]        rem_sub;
	logic                    ge;
	logic                    neg;
	logic                    launch;

	assign done     = (state_q == DL_DONE);
	assign res      = res_q;
	assign launch   = start && (state_q == DL_IDLE || state_q == DL_DONE);
	assign mul_busy = (cnt_q != '0);
	assign limb_idx = LIMB_IDX_W'(cnt_q - 1'b1);
	// Limbs are taken from the top down so the accumulator shifts by a fixed word.
	assign prod     = PROD_W'(a_q[limb_idx]) * PROD_W'(b_q);
	assign acc_next = (acc_q << 32) + ACC_W'(prod);
	assign rem_ext  = DSH_W'(rem_q);
	assign rem_sub  = rem_ext - dsh_q;
	assign ge       = (rem_ext >= dsh_q);
	assign neg      = (f2_q > SQ_W'(r2_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			DL_IDLE, DL_DONE: begin
				if (launch) begin
					if (freq == '0 || cfg.rf == '0) begin
						state_d = DL_DONE;
					end else begin
						state_d = DL_SQF;
					end
				end else begin
					state_d = DL_IDLE;
				end
			end
			DL_SQF:  if (!mul_busy) state_d = DL_SQR;
			DL_SQR:  if (!mul_busy) state_d = DL_DIFF;
			DL_DIFF: state_d = (cfg.ts == '0) ? DL_DONE : DL_NUM1;
			DL_NUM1: if (!mul_busy) state_d = DL_NUM2;
			DL_NUM2: if (!mul_busy) state_d = DL_DEN1;
			DL_DEN1: if (!mul_busy) state_d = DL_DEN2;
			DL_DEN2: if (!mul_busy) state_d = DL_DEN3;
			DL_DEN3: if (!mul_busy) state_d = DL_CHK;
			DL_CHK:  state_d = ge ? DL_DONE : DL_DIV;
			DL_DIV:  if (bit_q == '0) state_d = DL_FIN;
			DL_FIN:  state_d = DL_DONE;
			default: state_d = DL_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q   <= '0;
			b_q   <= '0;
			cnt_q <= '0;
			acc_q <= '0;
			f2_q  <= '0;
			r2_q  <= '0;
			neg_q <= 1'b0;
			rem_q <= '0;
			dsh_q <= '0;
			bit_q <= '0;
			q_q   <= '0;
			res_q <= '0;
		end else begin
			case (state_q)
				DL_IDLE, DL_DONE: begin
					if (launch) begin
						if (freq == '0) begin
							res_q <= '{start: START_MAX, sat: 1'b1};
						end else if (cfg.rf == '0) begin
							res_q <= '{start: START_MIN, sat: 1'b1};
						end else begin
							a_q   <= A_W'(freq);
							b_q   <= freq;
							cnt_q <= MUL_CNT_W'(2);
							acc_q <= '0;
						end
					end
				end
				DL_SQF: begin
					if (mul_busy) begin
						acc_q <= acc_next;
						cnt_q <= cnt_q - 1'b1;
					end else begin
						f2_q  <= acc_q[SQ_W-1:0];
						a_q   <= A_W'(cfg.rf);
						b_q   <= {1'b0, cfg.rf};
						cnt_q <= MUL_CNT_W'(1);
						acc_q <= '0;
					end
				end
				DL_SQR: begin
					if (mul_busy) begin
						acc_q <= acc_next;
						cnt_q <= cnt_q - 1'b1;
					end else begin
						r2_q <= acc_q[R2_W-1:0];
					end
				end
				DL_DIFF: begin
					neg_q <= neg;
					if (cfg.ts == '0) begin
						res_q <= '{start: (neg ? START_MIN : START_MAX), sat: 1'b1};
					end else begin
						a_q   <= A_W'(neg ? (f2_q - SQ_W'(r2_q)) : (SQ_W'(r2_q) - f2_q));
						b_q   <= DELAY_CONST;
						cnt_q <= MUL_CNT_W'(3);
						acc_q <= '0;
					end
				end
				DL_NUM1: begin
					if (mul_busy) begin
						acc_q <= acc_next;
						cnt_q <= cnt_q - 1'b1;
					end else begin
						a_q   <= acc_q[A_W-1:0];
						b_q   <= {1'b0, cfg.dm};
						cnt_q <= MUL_CNT_W'(3);
						acc_q <= '0;
					end
				end
				DL_NUM2: begin
					if (mul_busy) begin
						acc_q <= acc_next;
						cnt_q <= cnt_q - 1'b1;
					end else begin
						rem_q <= NUM_W'(acc_q[NUM_W-SCALE_SHIFT-1:0]) << SCALE_SHIFT;
						a_q   <= A_W'(f2_q);
						b_q   <= {1'b0, cfg.rf};
						cnt_q <= MUL_CNT_W'(3);
						acc_q <= '0;
					end
				end
				DL_DEN1: begin
					if (mul_busy) begin
						acc_q <= acc_next;
						cnt_q <= cnt_q - 1'b1;
					end else begin
						a_q   <= acc_q[A_W-1:0];
						b_q   <= {1'b0, cfg.rf};
						cnt_q <= MUL_CNT_W'(4);
						acc_q <= '0;
					end
				end
				DL_DEN2: begin
					if (mul_busy) begin
						acc_q <= acc_next;
						cnt_q <= cnt_q - 1'b1;
					end else begin
						a_q   <= acc_q[A_W-1:0];
						b_q   <= {1'b0, cfg.ts};
						cnt_q <= MUL_CNT_W'(5);
						acc_q <= '0;
					end
				end
				DL_DEN3: begin
					if (mul_busy) begin
						acc_q <= acc_next;
						cnt_q <= cnt_q - 1'b1;
					end else begin
						dsh_q <= DSH_W'(acc_q) << 32;
					end
				end
				DL_CHK: begin
					// A quotient of 2^32 or more cannot fit in any case.
					if (ge) begin
						res_q <= '{start: (neg_q ? START_MIN : START_MAX), sat: 1'b1};
					end else begin
						dsh_q <= dsh_q >> 1;
						bit_q <= BIT_W'(31);
						q_q   <= '0;
					end
				end
				DL_DIV: begin
					if (ge) begin
						rem_q        <= rem_sub[NUM_W-1:0];
						q_q[bit_q]   <= 1'b1;
					end
					dsh_q <= dsh_q >> 1;
					bit_q <= bit_q - 1'b1;
				end
				DL_FIN: begin
					if (!neg_q) begin
						if (q_q[WORD_W-1]) begin
							res_q <= '{start: START_MAX, sat: 1'b1};
						end else begin
							res_q <= '{start: $signed(q_q), sat: 1'b0};
						end
					end else if (q_q > 32'h8000_0000) begin
						res_q <= '{start: START_MIN, sat: 1'b1};
					end else begin
						res_q <= '{start: $signed(-q_q), sat: 1'b0};
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/dsi_back.sv =====
// ----------------------------------------------------------------------------
// dsi_back
// Takes jobs from the queue, runs the delay unit, forms window ends and the
// running width sum, and holds the result word for the receiver.
// ----------------------------------------------------------------------------
module dsi_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  dsi_pkg::job_t                     q_job,
	output logic                              pop,
	output logic                              dl_start,
	output logic [dsi_pkg::FREQ_X_W-1:0]      dl_freq,
	input  logic                              dl_done,
	input  dsi_pkg::delay_res_t               dl_res,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [dsi_pkg::CH_W-1:0]          channel_number,
	output logic signed [dsi_pkg::WORD_W-1:0] start_index,
	output logic signed [dsi_pkg::WORD_W-1:0] end_index,
	output logic [dsi_pkg::SUM_W-1:0]         width_total,
	output logic                              saturated,
	output logic                              run_end
);
	import dsi_pkg::*;

	bk_state_t                state_q;
	bk_state_t                state_d;
	job_t                     job_q;
	delay_res_t               main_q;
	delay_res_t               aux_q;
	logic signed [WORD_W-1:0] first_start_q;
	logic                     first_sat_q;
	logic signed [WORD_W-1:0] prev_q;
	logic [SUM_W-1:0]         sum_q;
	logic                     out_valid_q;

	logic                     out_free;
	logic                     load_first;
	logic                     load_last;
	logic signed [WORD_W-1:0] end0;
	logic signed [WORD_W-1:0] end_last;
	logic signed [WORD_W-1:0] last_prev;
	logic [SUM_W-1:0]         total0;
	logic [SUM_W-1:0]         total_last;

	// The window runs up to one bin short of the previous start, never below start.
	function automatic logic signed [WORD_W-1:0] win_end(
		input logic signed [WORD_W-1:0] s,
		input logic signed [WORD_W-1:0] p
	);
		logic signed [WORD_W:0] d;
		d = {p[WORD_W-1], p} - {s[WORD_W-1], s};
		if (d > 33'sd1) begin
			return p - 32'sd1;
		end
		return s;
	endfunction

	function automatic logic [SUM_W-1:0] win_width(
		input logic signed [WORD_W-1:0] s,
		input logic signed [WORD_W-1:0] e
	);
		logic [WORD_W:0] w;
		w = {e[WORD_W-1], e} - {s[WORD_W-1], s} + 33'd1;
		return SUM_W'(w);
	endfunction

	assign result_valid = out_valid_q;
	assign out_free     = !out_valid_q || !result_stall;

	always_comb begin
		end0       = win_end(first_start_q, aux_q.start);
		last_prev  = (job_q.kind == KIND_SECOND) ? first_start_q : prev_q;
		end_last   = (job_q.kind == KIND_LONE) ? main_q.start : win_end(main_q.start, last_prev);
		total0     = sum_q + win_width(first_start_q, end0);
		total_last = sum_q + win_width(main_q.start, end_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		dl_start   = 1'b0;
		dl_freq    = {1'b0, q_job.freq};
		load_first = 1'b0;
		load_last  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pop      = 1'b1;
					dl_start = 1'b1;
					state_d  = BK_MAIN;
				end
			end
			BK_MAIN: begin
				if (dl_done) begin
					case (job_q.kind)
						KIND_HOLD: state_d = BK_IDLE;
						KIND_SECOND: begin
							dl_start = 1'b1;
							dl_freq  = job_q.aux_freq;
							state_d  = BK_AUX;
						end
						default: state_d = BK_OUT_LAST;
					endcase
				end
			end
			BK_AUX: begin
				if (dl_done) begin
					state_d = BK_OUT_FIRST;
				end
			end
			BK_OUT_FIRST: begin
				if (out_free) begin
					load_first = 1'b1;
					state_d    = BK_OUT_LAST;
				end
			end
			BK_OUT_LAST: begin
				if (out_free) begin
					load_last = 1'b1;
					state_d   = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_start_q <= '0;
			first_sat_q   <= 1'b0;
			prev_q        <= '0;
			sum_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (state_q == BK_MAIN && dl_done && job_q.kind == KIND_HOLD) begin
				first_start_q <= dl_res.start;
				first_sat_q   <= dl_res.sat;
				prev_q        <= dl_res.start;
			end
			if (load_first) begin
				sum_q <= total0;
			end
			if (load_last) begin
				sum_q  <= job_q.fin ? '0 : total_last;
				prev_q <= main_q.start;
			end
			if (load_first || load_last) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
		end
		if (state_q == BK_MAIN && dl_done) begin
			main_q <= dl_res;
		end
		if (state_q == BK_AUX && dl_done) begin
			// Channel zero's word also carries the imaginary channel's flag.
			aux_q <= '{start: dl_res.start, sat: dl_res.sat | first_sat_q};
		end
		if (load_first) begin
			channel_number <= '0;
			start_index    <= first_start_q;
			end_index      <= end0;
			width_total    <= total0;
			saturated      <= aux_q.sat;
			run_end        <= 1'b0;
		end else if (load_last) begin
			channel_number <= job_q.ch;
			start_index    <= main_q.start;
			end_index      <= end_last;
			width_total    <= total_last;
			saturated      <= main_q.sat;
			run_end        <= job_q.fin;
		end
	end

endmodule

// ===== tb/dedispersion_select_index_check.sv =====
// ----------------------------------------------------------------------------
// dedispersion_select_index_check
// Watches the channel, result and register channels of the select index
// core, predicts every result word from the accepted channel words and
// compares each accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module dedispersion_select_index_check (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	input  logic                                item_stall,
	input  logic [dsi_pkg::WORD_W-1:0]          freq_mhz,
	input  logic                                final_channel,
	input  logic                                result_valid,
	input  logic                                result_stall,
	input  logic [dsi_pkg::CH_W-1:0]            channel_number,
	input  logic signed [dsi_pkg::WORD_W-1:0]   start_index,
	input  logic signed [dsi_pkg::WORD_W-1:0]   end_index,
	input  logic [dsi_pkg::SUM_W-1:0]           width_total,
	input  logic                                saturated,
	input  logic                                run_end,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [dsi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dsi_pkg::WORD_W-1:0]          cfg_data,
	output int                                  fail_count,
	output int                                  words_pending,
	output int                                  words_checked
);
	import dsi_pkg::*;

	typedef struct {
		logic [CH_W-1:0]          ch;
		logic signed [WORD_W-1:0] start;
		logic signed [WORD_W-1:0] stop;
		logic [SUM_W-1:0]         total;
		logic                     sat;
		logic                     last;
	} window_t;

	window_t expected_windows[$];

	logic [WORD_W-1:0]        dm_reg, ts_reg, rf_reg;
	logic [12:0]              chan_count;
	logic [WORD_W-1:0]        chan0_freq;
	logic signed [WORD_W-1:0] chan0_start;
	bit                       chan0_sat;
	logic signed [WORD_W-1:0] prev_start;
	logic [SUM_W-1:0]         width_acc;

	// Delay in time bins for one frequency, truncated toward zero.
	function automatic logic signed [WORD_W-1:0] delay_bins(input logic [32:0] f,
			inout bit sat);
		logic [255:0] f2, r2, diff, num, den, q;
		bit neg;
		if (f == 0) begin
			sat = 1;
			return START_MAX;
		end
		if (rf_reg == 0) begin
			sat = 1;
			return START_MIN;
		end
		f2 = 256'(f);
		f2 = f2 * f2;
		r2 = 256'(rf_reg);
		r2 = r2 * r2;
		neg = f2 > r2;
		if (ts_reg == 0) begin
			sat = 1;
			return neg ? START_MIN : START_MAX;
		end
		diff = neg ? f2 - r2 : r2 - f2;
		num = ((diff * 256'd4150) * 256'(dm_reg)) << 40;
		den = (f2 * r2) * 256'(ts_reg);
		q = num / den;
		if (q >= (256'd1 << 32)) begin
			sat = 1;
			return neg ? START_MIN : START_MAX;
		end
		if (!neg) begin
			if (q > 256'h7FFFFFFF) begin
				sat = 1;
				return START_MAX;
			end
			return q[31:0];
		end
		if (q > 256'h80000000) begin
			sat = 1;
			return START_MIN;
		end
		return -q[31:0];
	endfunction

	function automatic logic signed [WORD_W-1:0] smear_end(
			input logic signed [WORD_W-1:0] start, input logic signed [WORD_W-1:0] prev,
			inout bit sat);
		longint size, e;
		size = longint'(prev) - longint'(start) - 1;
		if (size < 0)
			size = 0;
		e = longint'(start) + size;
		if (e > 64'sh7FFFFFFF) begin
			sat = 1;
			e = 64'sh7FFFFFFF;
		end
		return e[31:0];
	endfunction

	function automatic void add_window(input logic [12:0] ch,
			input logic signed [WORD_W-1:0] start, input logic signed [WORD_W-1:0] stop,
			input bit sat, input bit last);
		window_t w;
		longint width;
		width = longint'(stop) - longint'(start) + 1;
		width_acc = width_acc + width[SUM_W-1:0];
		w.ch = ch[CH_W-1:0];
		w.start = start;
		w.stop = stop;
		w.total = width_acc;
		w.sat = sat;
		w.last = last;
		expected_windows.push_back(w);
	endfunction

	task automatic predict_channel(input logic [WORD_W-1:0] f, input bit fin_in);
		bit fin, s, s0;
		logic signed [WORD_W-1:0] start, stop, c0start, end0;
		logic [32:0] two, c0;
		fin = fin_in;
		s = 0;
		if (32'(chan_count) + 1 >= MAX_CHANNELS)
			fin = 1;
		start = delay_bins({1'b0, f}, s);
		if (chan_count == 0) begin
			if (!fin) begin
				chan0_freq = f;
				chan0_start = start;
				chan0_sat = s;
				prev_start = start;
				chan_count = 1;
				return;
			end
			add_window(0, start, start, s, 1);
		end else if (chan_count == 1) begin
			two = {chan0_freq, 1'b0};
			c0 = two >= {1'b0, f} ? two - {1'b0, f} : {1'b0, f} - two;
			s0 = chan0_sat;
			c0start = delay_bins(c0, s0);
			end0 = smear_end(chan0_start, c0start, s0);
			add_window(0, chan0_start, end0, s0, 0);
			stop = smear_end(start, chan0_start, s);
			add_window(1, start, stop, s, fin);
		end else begin
			stop = smear_end(start, prev_start, s);
			add_window(chan_count, start, stop, s, fin);
		end
		prev_start = start;
		if (fin) begin
			chan_count = 0;
			width_acc = 0;
		end else begin
			chan_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		window_t w;
		if (!arst_n) begin
			dm_reg = DM_RESET;
			ts_reg = TS_RESET;
			rf_reg = RF_RESET;
			chan_count = 0;
			chan0_freq = 0;
			chan0_start = 0;
			chan0_sat = 0;
			prev_start = 0;
			width_acc = 0;
			expected_windows.delete();
			fail_count = 0;
			words_checked = 0;
		end else begin
			if (result_valid && !result_stall) begin
				words_checked++;
				if (expected_windows.size() == 0) begin
					$error("result word with none expected: channel %0d", channel_number);
					fail_count++;
				end else begin
					w = expected_windows.pop_front();
					if (channel_number !== w.ch) begin
						$error("channel_number expected %0d got %0d", w.ch, channel_number);
						fail_count++;
					end
					if (start_index !== w.start) begin
						$error("start_index expected %0d got %0d", w.start, start_index);
						fail_count++;
					end
					if (end_index !== w.stop) begin
						$error("end_index expected %0d got %0d", w.stop, end_index);
						fail_count++;
					end
					if (width_total !== w.total) begin
						$error("width_total expected %0d got %0d", w.total, width_total);
						fail_count++;
					end
					if (saturated !== w.sat) begin
						$error("saturated expected %0b got %0b", w.sat, saturated);
						fail_count++;
					end
					if (run_end !== w.last) begin
						$error("run_end expected %0b got %0b", w.last, run_end);
						fail_count++;
					end
				end
			end
			if (item_valid && !item_stall)
				predict_channel(freq_mhz, final_channel);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DM: dm_reg = cfg_data;
					CFG_TS: ts_reg = cfg_data;
					CFG_RF: rf_reg = cfg_data;
					default: ;
				endcase
			end
		end
		words_pending = expected_windows.size();
	end

endmodule

// ===== tb/dedispersion_select_index_core_test.sv =====
// ----------------------------------------------------------------------------
// dedispersion_select_index_core_test
// Drives channel lists through the select index core under several register
// settings, with random gaps and stalls on both sides and one long hold-off
// of the result side; a checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module dedispersion_select_index_core_test;
	import dsi_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int SETTLE      = 200;

	logic                      clk;
	logic                      arst_n;
	logic                      item_valid;
	logic                      item_stall;
	logic [WORD_W-1:0]         freq_mhz;
	logic                      final_channel;
	logic                      result_valid;
	logic                      result_stall;
	logic [CH_W-1:0]           channel_number;
	logic signed [WORD_W-1:0]  start_index;
	logic signed [WORD_W-1:0]  end_index;
	logic [SUM_W-1:0]          width_total;
	logic                      saturated;
	logic                      run_end;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [WORD_W-1:0]         cfg_data;

	int  fail_count, words_pending, words_checked;
	int  cycle_count;
	int  channels_sent;
	int  settings_used;
	bit  tx_quiet, rx_quiet, hold_off_req;

	dedispersion_select_index_core u_top (.*);

	dedispersion_select_index_check u_check (.*);

	initial clk = 0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Result side: a random stall before each word, and one long hold-off.
	initial begin
		int n;
		result_stall = 0;
		@(posedge arst_n);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 0;
				result_stall <= 1;
				n = 0;
				while (n < 3000) begin
					@(posedge clk);
					n++;
				end
				result_stall <= 0;
			end else begin
				n = rx_quiet ? 0 : $urandom_range(0, 15);
				if (n > 0) begin
					result_stall <= 1;
					repeat (n) @(posedge clk);
					result_stall <= 0;
				end
			end
			@(posedge clk);
			while (!(result_valid && !result_stall))
				@(posedge clk);
		end
	end

	task automatic send_channel(input logic [WORD_W-1:0] f, input bit fin);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			item_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1;
		freq_mhz <= f;
		final_channel <= fin;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		channels_sent++;
	endtask

	task automatic drain();
		item_valid <= 0;
		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes all three registers back to back; only called once drained.
	task automatic write_regs(input logic [WORD_W-1:0] dm, input logic [WORD_W-1:0] ts,
			input logic [WORD_W-1:0] rf);
		logic [WORD_W-1:0] vals[3];
		logic [CFG_IDX_W-1:0] idx[3];
		vals = '{dm, ts, rf};
		idx = '{CFG_DM, CFG_TS, CFG_RF};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 0;
		settings_used++;
	endtask

	// One list of channels; mostly ascending within a band, sometimes noise.
	task automatic send_list(input int len, input bit wild);
		logic [WORD_W-1:0] f;
		f = wild ? $urandom : $urandom_range(20 << 16, 800 << 16);
		for (int i = 0; i < len; i++) begin
			send_channel(f, i == len - 1);
			if (wild)
				f = $urandom;
			else
				f = f + $urandom_range(1, 1 << 20);
		end
	endtask

	initial begin
		int len;
		arst_n = 0;
		item_valid = 0;
		freq_mhz = 0;
		final_channel = 0;
		cfg_valid = 0;
		cfg_index = CFG_DM;
		cfg_data = 0;
		cycle_count = 0;
		channels_sent = 0;
		settings_used = 0;
		tx_quiet = 0;
		rx_quiet = 0;
		hold_off_req = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Reset settings first: zero DM gives zero delays.
		send_channel(100 << 16, 0);
		send_channel(120 << 16, 1);
		drain();

		write_regs(50 << 16, 16777, 400 << 16);
		send_channel(300 << 16, 1);                // lone channel
		send_channel(0, 0);                        // zero frequency on channel 0
		send_channel(100 << 16, 1);
		send_channel(100 << 16, 0);                // imaginary channel at zero
		send_channel(200 << 16, 1);
		send_channel(32'hFFFFFFFF, 0);             // extremes, out of order
		send_channel(1, 0);
		send_channel(32'h80000000, 0);
		send_channel(32'h7FFFFFFF, 1);
		send_list(4, 0);
		drain();

		write_regs(32'hFFFFFFFF, 1, 0);             // zero reference
		send_list(3, 0);
		drain();
		write_regs(1000 << 16, 0, 32'hFFFFFFFF);    // zero time step
		send_list(3, 0);
		send_channel(32'hFFFFFFFF, 1);
		drain();
		write_regs(32'hFFFFFFFF, 1, 65536);          // wide delays, saturation
		send_list(4, 0);
		drain();

		// Random part, with the long result hold-off early on.
		hold_off_req = 1;
		while (channels_sent < 1880) begin
			case ($urandom_range(0, 5))
				0: write_regs($urandom, $urandom, $urandom);
				1: write_regs($urandom_range(0, 2000 << 16), $urandom_range(1, 1 << 20),
						$urandom_range(20 << 16, 800 << 16));
				default: write_regs($urandom_range(0, 200 << 16), $urandom_range(1000, 40000),
						$urandom_range(100 << 16, 500 << 16));
			endcase
			tx_quiet = $urandom_range(0, 3) == 0;
			rx_quiet = $urandom_range(0, 3) == 0;
			for (int r = 0; r < 12; r++) begin
				len = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60)
						: $urandom_range(1, 10);
				send_list(len, $urandom_range(0, 9) == 0);
			end
			drain();
		end

		$display("Sent %0d channel words under %0d register settings; checked %0d result words.",
				channels_sent, settings_used, words_checked);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/dsi_pkg.sv
rtl/dsi_queue.sv
rtl/dsi_front.sv
rtl/dsi_delay.sv
rtl/dsi_back.sv
rtl/dedispersion_select_index_core.sv
tb/dedispersion_select_index_check.sv
tb/dedispersion_select_index_core_test.sv
